// File: hw/rtl/prd_pkg.sv
// Shared types and constants for the pool record deframer.
// No dependencies; every other RTL file refers to this package by scoped names.
`default_nettype none

package prd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned REP_W    = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SUM_W    = 30;
  localparam int unsigned DCNT_W   = 4;

  localparam logic [SUM_W-1:0] CHECKSUM_RESET = 30'd117275187;

  localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;

  typedef enum logic [2:0] {
    PH_HDR1 = 3'd0,
    PH_HDR2 = 3'd1,
    PH_DATA = 3'd2,
    PH_SKIP = 3'd3,
    PH_CSUM = 3'd4,
    PH_DONE = 3'd5,
    PH_ERR  = 3'd6
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DATA     = 3'd0,
    ST_OK       = 3'd1,
    ST_NOSUM    = 3'd2,
    ST_BADDIG   = 3'd3,
    ST_MISMATCH = 3'd4,
    ST_BADLEN   = 3'd5
  } status_t;

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/prd_if.sv
// Valid/ready stream interfaces for the deframer's byte input and result output.
// Depends on prd_pkg for field widths.
`default_nettype none

interface prd_in_if;
  logic                          valid;
  logic                          ready;
  logic [prd_pkg::BYTE_W-1:0]    in_byte;
  logic                          stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface prd_out_if;
  logic                          valid;
  logic                          ready;
  logic [prd_pkg::BYTE_W-1:0]    out_byte;
  logic [prd_pkg::REP_W-1:0]     repeat_res;
  logic                          end_of_string;
  logic [prd_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output out_byte, output repeat_res,
                  output end_of_string, output status, input ready);
  modport sink   (input valid, input out_byte, input repeat_res,
                  input end_of_string, input status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pool_record_deframer.sv
// Pool record deframer: top level, single module.
// Depends on prd_pkg and the prd_in_if / prd_out_if stream interfaces.
//
// Takes one stream byte per transaction and yields at most one result per byte.
// Each byte lands in an input register, the parser state update and result
// formation are one short combinational step (the widest part is the checksum
// multiply-by-ten-and-add plus its compare), and the result lands in an output
// register. Sustained rate is one byte per cycle while the sink keeps
// out_ch.ready high; when a result is stalled, the input register still takes
// one more transaction before in_ch.ready drops. A result reaches out_ch when
// its byte moves from the input register into a free output register. Records
// are a two-digit length and that many string bytes, a '*' record holds
// CHECKSUM_DIGITS decimal digits checked against the value written through
// cfg_wdata into expected_r. After a done or error status the block
// swallows every further byte until reset. Write cfg only while idle.
`default_nettype none

module pool_record_deframer #(
  parameter int unsigned CHECKSUM_DIGITS = 9
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [prd_pkg::SUM_W-1:0]   cfg_wdata,
  prd_in_if.sink                           in_ch,
  prd_out_if.source                        out_ch
);

  localparam logic [prd_pkg::DCNT_W-1:0] NDIG = prd_pkg::DCNT_W'(CHECKSUM_DIGITS);

  // Configuration register.
  logic [prd_pkg::SUM_W-1:0] expected_r;

  // Input register.
  logic                          s1_valid_r;
  logic [prd_pkg::BYTE_W-1:0]    s1_byte_r;
  logic                          s1_end_r;

  // Parser state.
  prd_pkg::phase_t               phase_r, phase_nxt;
  logic [prd_pkg::BYTE_W-1:0]    tens_r, tens_nxt;
  logic [prd_pkg::REP_W-1:0]     left_r, left_nxt;
  logic [prd_pkg::DCNT_W-1:0]    dcnt_r, dcnt_nxt;
  logic [prd_pkg::SUM_W-1:0]     sum_r, sum_nxt;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  logic [prd_pkg::BYTE_W-1:0]    out_byte_r, res_byte;
  logic [prd_pkg::REP_W-1:0]     out_rep_r, res_rep;
  logic                          out_eos_r, res_eos;
  prd_pkg::status_t              out_st_r, res_st;
  logic                          res_valid;

  logic advance;

  // Checksum digit helper values.
  logic                          csum_first;
  logic [prd_pkg::SUM_W-1:0]     sum_base, sum_acc;
  logic [prd_pkg::DCNT_W-1:0]    dcnt_base, dcnt_acc;
  logic [3:0]                    tens_val, unit_val;

  // The input register moves on whenever the output register is free or drained.
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = out_byte_r;
  assign out_ch.repeat_res    = out_rep_r;
  assign out_ch.end_of_string = out_eos_r;
  assign out_ch.status        = out_st_r;

  // A '*' header restarts the accumulation from zero on its second byte.
  assign csum_first = (phase_r == prd_pkg::PH_HDR2);
  assign sum_base   = csum_first ? '0 : sum_r;
  assign dcnt_base  = csum_first ? '0 : dcnt_r;
  assign sum_acc    = (sum_base << 3) + (sum_base << 1)
                    + prd_pkg::SUM_W'(s1_byte_r[3:0]);
  assign dcnt_acc   = dcnt_base + 1'b1;

  assign tens_val = tens_r[3:0];
  assign unit_val = s1_byte_r[3:0];

  always_comb begin
    phase_nxt = phase_r;
    tens_nxt  = tens_r;
    left_nxt  = left_r;
    dcnt_nxt  = dcnt_r;
    sum_nxt   = sum_r;
    res_valid = 1'b0;
    res_byte  = '0;
    res_rep   = '0;
    res_eos   = 1'b0;
    res_st    = prd_pkg::ST_DATA;

    if (phase_r == prd_pkg::PH_DONE || phase_r == prd_pkg::PH_ERR) begin
      // Swallow everything until reset.
    end else if (s1_end_r) begin
      phase_nxt = prd_pkg::PH_ERR;
      res_valid = 1'b1;
      res_st    = prd_pkg::ST_NOSUM;
    end else begin
      case (phase_r)
        prd_pkg::PH_HDR1: begin
          tens_nxt  = s1_byte_r;
          phase_nxt = prd_pkg::PH_HDR2;
        end
        prd_pkg::PH_HDR2, prd_pkg::PH_CSUM: begin
          if (phase_r == prd_pkg::PH_HDR2 && tens_r != prd_pkg::CH_STAR) begin
            // Length header.
            if (!prd_pkg::is_digit(tens_r) || !prd_pkg::is_digit(s1_byte_r)) begin
              phase_nxt = prd_pkg::PH_ERR;
              res_valid = 1'b1;
              res_st    = prd_pkg::ST_BADLEN;
            end else begin
              left_nxt = prd_pkg::REP_W'({tens_val, 3'b000})
                       + prd_pkg::REP_W'({tens_val, 1'b0})
                       + prd_pkg::REP_W'(unit_val);
              if (tens_val == 4'd0 && unit_val == 4'd0) begin
                phase_nxt = prd_pkg::PH_SKIP;
                res_valid = 1'b1;
                res_eos   = 1'b1;
              end else begin
                phase_nxt = prd_pkg::PH_DATA;
              end
            end
          end else begin
            // Checksum digit.
            if (!prd_pkg::is_digit(s1_byte_r)) begin
              phase_nxt = prd_pkg::PH_ERR;
              res_valid = 1'b1;
              res_st    = prd_pkg::ST_BADDIG;
            end else begin
              sum_nxt  = sum_acc;
              dcnt_nxt = dcnt_acc;
              if (dcnt_acc >= NDIG) begin
                res_valid = 1'b1;
                if (sum_acc != expected_r) begin
                  phase_nxt = prd_pkg::PH_ERR;
                  res_st    = prd_pkg::ST_MISMATCH;
                end else begin
                  phase_nxt = prd_pkg::PH_DONE;
                  res_st    = prd_pkg::ST_OK;
                end
              end else begin
                phase_nxt = prd_pkg::PH_CSUM;
              end
            end
          end
        end
        prd_pkg::PH_DATA: begin
          res_valid = 1'b1;
          if (s1_byte_r == prd_pkg::CH_NEWLINE) begin
            // Early newline: pad the rest with spaces.
            res_byte  = prd_pkg::CH_SPACE;
            res_rep   = left_r;
            res_eos   = 1'b1;
            left_nxt  = '0;
            phase_nxt = prd_pkg::PH_HDR1;
          end else begin
            res_byte = s1_byte_r;
            res_rep  = prd_pkg::REP_W'(1);
            left_nxt = left_r - 1'b1;
            if (left_r == prd_pkg::REP_W'(1)) begin
              res_eos   = 1'b1;
              phase_nxt = prd_pkg::PH_SKIP;
            end
          end
        end
        prd_pkg::PH_SKIP: begin
          if (s1_byte_r == prd_pkg::CH_NEWLINE) begin
            phase_nxt = prd_pkg::PH_HDR1;
          end
        end
        default: begin
          phase_nxt = prd_pkg::PH_ERR;
          res_valid = 1'b1;
          res_st    = prd_pkg::ST_NOSUM;
        end
      endcase
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = res_valid;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state and parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r  <= prd_pkg::CHECKSUM_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= prd_pkg::PH_HDR1;
      tens_r      <= '0;
      left_r      <= '0;
      dcnt_r      <= '0;
      sum_r       <= '0;
    end else begin
      if (cfg_we) begin
        expected_r <= cfg_wdata;
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        phase_r <= phase_nxt;
        tens_r  <= tens_nxt;
        left_r  <= left_nxt;
        dcnt_r  <= dcnt_nxt;
        sum_r   <= sum_nxt;
      end
    end
  end

  // Payload registers: hold on stall, load on transaction or advance.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.in_byte;
      s1_end_r  <= in_ch.stream_end;
    end
    if (advance && res_valid) begin
      out_byte_r <= res_byte;
      out_rep_r  <= res_rep;
      out_eos_r  <= res_eos;
      out_st_r   <= res_st;
    end
  end

endmodule

`default_nettype wire
